// ===== src/lts_pkg.sv =====
// lottery ticket scheduler package: sizes, command codes, slot entry and
// accumulator control types; no dependencies
package lts_pkg;

    localparam int SLOTS = 64;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int TOT_W = IDX_W + 16;
    localparam int CMP_W = (TOT_W > 22) ? TOT_W : 22;
    localparam logic [21:0] TOTAL_MAX = 22'h3FFFFF;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_DRAW   = 2'd1,
        CMD_CHARGE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [31:0] ticks;
        logic        run;
        logic [15:0] tk;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             clr;
        logic             en;
        logic [TOT_W-1:0] add;
        logic [21:0]      want;
    } acc_ctl_t;

    typedef struct packed {
        logic hit;
    } acc_sts_t;

endpackage

// ===== src/lts_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module lts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lts_accum.sv =====
// shared ticket accumulator: running sum with add and compare against the drawn number
// depends on lts_pkg
module lts_accum (
    input  logic             aclk,
    input  logic             aresetn,
    input  lts_pkg::acc_ctl_t ctl,
    output lts_pkg::acc_sts_t sts
);
    import lts_pkg::*;

    logic [TOT_W-1:0] acc_reg, acc_next;
    logic [TOT_W-1:0] sum;

    assign sum     = acc_reg + ctl.add;
    assign sts.hit = CMP_W'(sum) >= CMP_W'(ctl.want);

    always_comb begin
        acc_next = acc_reg;
        if (ctl.clr) begin
            acc_next = '0;
        end else if (ctl.en) begin
            acc_next = sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== src/lottery_ticket_scheduler.sv =====
// Lottery ticket scheduler top level: slot table in one ram with per-slot valid bits,
// a sequencer and the shared accumulator. Depends on lts_pkg, lts_ram, lts_accum.
// Every input beat gives one result beat. Set, charge and read beats go from accept to
// result through one ram read, an update state and the output register. A draw reads one
// slot per cycle through the single ram read port and adds its tickets, if runnable, in
// the shared accumulator, stopping at the winner or after the last slot when no slot wins.
// The input is not ready until the current beat's result has been handed to the output
// register. Reset is synchronous; valid bits make unwritten slots read as one ticket, not
// runnable, zero ticks.
module lottery_ticket_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot, ticket_count, runnable_in, winning_ticket, elapsed_ticks
    input  logic [63:0] s_tdata,
    // cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // winner_found, winner_slot, ticket_total, slot_tickets, slot_runnable, slot_ticks
    output logic [79:0] m_tdata
);
    import lts_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    cmd_t        cmd_reg, cmd_next;
    logic [5:0]  slot_reg, slot_next;
    logic [15:0] tk_reg, tk_next;
    logic        run_reg, run_next;
    logic [21:0] want_reg, want_next;
    logic [15:0] elapsed_reg, elapsed_next;

    logic [TOT_W-1:0] total_reg, total_next;
    logic [SLOTS-1:0] vld_reg, vld_next;
    logic             rd_vld_reg;

    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issue_on_reg, issue_on_next;
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;
    logic             eval_vld_reg, eval_vld_next;

    logic [79:0] res_reg, res_next;
    logic [79:0] m_tdata_reg, m_tdata_next;
    logic        m_tvalid_reg, m_tvalid_next;

    logic             accept;
    logic             we;
    logic [IDX_W-1:0] raddr;
    logic [ENTRY_W-1:0] rdata;
    entry_t           q, old_ent, new_ent, slot_ent;
    logic [32:0]      tick_sum;
    logic             slot_ok;
    logic [IDX_W-1:0] slot_idx;
    logic [21:0]      total_sat;
    logic [TOT_W-1:0] total_after;
    acc_ctl_t         acc_ctl;
    acc_sts_t         acc_sts;
    logic             e_run;
    logic [15:0]      e_tk;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign slot_idx = IDX_W'(slot_reg);
    assign slot_ok  = (32'(slot_reg) < SLOTS);
    assign q        = entry_t'(rdata);

    always_comb begin
        old_ent.tk    = rd_vld_reg ? q.tk : 16'd1;
        old_ent.run   = rd_vld_reg & q.run;
        old_ent.ticks = rd_vld_reg ? q.ticks : 32'd0;
        tick_sum      = {1'b0, old_ent.ticks} + 33'(elapsed_reg);
        new_ent       = old_ent;
        if (cmd_reg == CMD_SET) begin
            new_ent.tk  = tk_reg;
            new_ent.run = run_reg;
        end else if (cmd_reg == CMD_CHARGE) begin
            new_ent.ticks = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
        end
        slot_ent = slot_ok ? new_ent : '0;
    end

    assign we = (state_reg == ST_EXEC) && slot_ok
             && ((cmd_reg == CMD_SET) || (cmd_reg == CMD_CHARGE));

    always_comb begin
        total_after = total_reg;
        if ((state_reg == ST_EXEC) && slot_ok && (cmd_reg == CMD_SET)) begin
            total_after = total_reg - (old_ent.run ? TOT_W'(old_ent.tk) : '0)
                        + (run_reg ? TOT_W'(tk_reg) : '0);
        end
        total_sat = (CMP_W'(total_after) > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX : 22'(total_after);
    end

    always_comb begin
        raddr = IDX_W'(s_tdata[5:0]);
        if (state_reg == ST_SCAN) begin
            raddr = scan_idx_reg;
        end
    end

    assign e_tk  = rd_vld_reg ? q.tk : 16'd1;
    assign e_run = rd_vld_reg & q.run;

    always_comb begin
        acc_ctl.clr  = accept;
        acc_ctl.en   = (state_reg == ST_SCAN) && eval_vld_reg && e_run;
        acc_ctl.add  = TOT_W'(e_tk);
        acc_ctl.want = want_reg;
    end

    lts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (slot_idx),
        .wdata (new_ent),
        .raddr (raddr),
        .rdata (rdata)
    );

    lts_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .sts     (acc_sts)
    );

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        slot_next     = slot_reg;
        tk_next       = tk_reg;
        run_next      = run_reg;
        want_next     = want_reg;
        elapsed_next  = elapsed_reg;
        total_next    = total_reg;
        vld_next      = vld_reg;
        scan_idx_next = scan_idx_reg;
        issue_on_next = issue_on_reg;
        eval_idx_next = eval_idx_reg;
        eval_vld_next = 1'b0;
        res_next      = res_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next      = cmd_t'(s_tuser);
                    slot_next     = s_tdata[5:0];
                    tk_next       = s_tdata[21:6];
                    run_next      = s_tdata[22];
                    want_next     = s_tdata[44:23];
                    elapsed_next  = s_tdata[60:45];
                    scan_idx_next = '0;
                    issue_on_next = 1'b1;
                    state_next    = (cmd_t'(s_tuser) == CMD_DRAW) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC: begin
                total_next = total_after;
                if (we) begin
                    vld_next[slot_idx] = 1'b1;
                end
                res_next   = {2'b00, slot_ent.ticks, slot_ent.run, slot_ent.tk,
                              total_sat, 6'd0, 1'b0};
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                if (issue_on_reg) begin
                    eval_vld_next = 1'b1;
                    eval_idx_next = scan_idx_reg;
                    if (scan_idx_reg == IDX_W'(SLOTS - 1)) begin
                        issue_on_next = 1'b0;
                    end else begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (eval_vld_reg) begin
                    if (acc_ctl.en && acc_sts.hit) begin
                        res_next      = {2'b00, 32'd0, 1'b0, 16'd0, total_sat,
                                         6'(eval_idx_reg), 1'b1};
                        issue_on_next = 1'b0;
                        eval_vld_next = 1'b0;
                        state_next    = ST_DONE;
                    end else if (eval_idx_reg == IDX_W'(SLOTS - 1)) begin
                        res_next      = {2'b00, 32'd0, 1'b0, 16'd0, total_sat, 6'd0, 1'b0};
                        issue_on_next = 1'b0;
                        eval_vld_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            issue_on_reg <= 1'b0;
            eval_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            vld_reg      <= vld_next;
            rd_vld_reg   <= vld_reg[raddr];
            issue_on_reg <= issue_on_next;
            eval_vld_reg <= eval_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        slot_reg     <= slot_next;
        tk_reg       <= tk_next;
        run_reg      <= run_next;
        want_reg     <= want_next;
        elapsed_reg  <= elapsed_next;
        scan_idx_reg <= scan_idx_next;
        eval_idx_reg <= eval_idx_next;
        res_reg      <= res_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule

// ===== verif/tb_lottery_ticket_scheduler.sv =====
// testbench for lottery_ticket_scheduler: directed table and random traffic with random
// stalls on both streams, checked against a slot table model or hand-set expectations
// depends on lts_pkg and the lottery_ticket_scheduler rtl
`timescale 1ns / 1ps

module tb_lottery_ticket_scheduler;
    import lts_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [5:0]  slot;
        logic [15:0] tk;
        logic        run;
        logic [21:0] want;
        logic [15:0] elapsed;
    } sched_item_t;

    typedef struct {
        logic        found;
        logic [5:0]  wslot;
        logic [21:0] total;
        logic [15:0] tk;
        logic        run;
        logic [31:0] ticks;
    } sched_result_t;

    typedef struct {
        sched_item_t   item;
        bit            has_exp;
        sched_result_t exp;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam int RAND_ITEMS = 850;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_READ;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    logic [15:0] tk_model [SLOTS];
    logic        run_model [SLOTS];
    logic [31:0] ticks_model [SLOTS];

    sched_result_t sched_results_q[$];
    dir_row_t      dir_rows [DIR_ROWS];
    int            fails = 0;
    bit            no_idle = 1'b0;
    bit            stall_rx = 1'b0;
    int            rx_wait = 0;
    int            rand_sent = 0;

    lottery_ticket_scheduler DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [31:0] runnable_sum();
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (run_model[i]) acc += tk_model[i];
        end
        return acc;
    endfunction

    function automatic sched_result_t slot_table_step(sched_item_t it);
        sched_result_t r;
        logic [32:0]   sum;
        logic [31:0]   acc;
        logic [31:0]   tot;
        r = '{default: '0};
        if (it.cmd == CMD_SET) begin
            tk_model[it.slot] = it.tk;
            run_model[it.slot] = it.run;
        end else if (it.cmd == CMD_CHARGE) begin
            sum = {1'b0, ticks_model[it.slot]} + 33'(it.elapsed);
            ticks_model[it.slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        if (it.cmd == CMD_DRAW) begin
            acc = '0;
            for (int i = 0; i < SLOTS; i++) begin
                if (run_model[i]) begin
                    acc += tk_model[i];
                    if (acc >= {10'd0, it.want}) begin
                        r.found = 1'b1;
                        r.wslot = i[5:0];
                        break;
                    end
                end
            end
        end else begin
            r.tk = tk_model[it.slot];
            r.run = run_model[it.slot];
            r.ticks = ticks_model[it.slot];
        end
        tot = runnable_sum();
        r.total = (tot > {10'd0, TOTAL_MAX}) ? TOTAL_MAX : tot[21:0];
        return r;
    endfunction

    function automatic dir_row_t row(cmd_t cmd, int slot, int tk, int run, int want,
                                     int elapsed);
        dir_row_t d;
        d.item = '{cmd, slot[5:0], tk[15:0], run[0], want[21:0], elapsed[15:0]};
        d.has_exp = 1'b0;
        d.exp = '{default: '0};
        return d;
    endfunction

    function automatic dir_row_t row_exp(dir_row_t d, int found, int wslot, int total,
                                         int tk, int run, longint ticks);
        d.has_exp = 1'b1;
        d.exp = '{found[0], wslot[5:0], total[21:0], tk[15:0], run[0], ticks[31:0]};
        return d;
    endfunction

    task automatic send_item(sched_item_t it, sched_result_t exp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        sched_results_q.push_back(exp);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= it.cmd;
        s_tdata <= {3'd0, it.elapsed, it.want, it.run, it.tk, it.slot};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(negedge aclk) begin
        if (stall_rx) begin
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        sched_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (sched_results_q.size() == 0) begin
                $error("result beat with no expectation pending");
                fails++;
            end else begin
                e = sched_results_q.pop_front();
                check_field("winner_found", 32'(e.found), 32'(m_tdata[0]));
                check_field("winner_slot", 32'(e.wslot), 32'(m_tdata[6:1]));
                check_field("ticket_total", 32'(e.total), 32'(m_tdata[28:7]));
                check_field("slot_tickets", 32'(e.tk), 32'(m_tdata[44:29]));
                check_field("slot_runnable", 32'(e.run), 32'(m_tdata[45]));
                check_field("slot_ticks", e.ticks, m_tdata[77:46]);
            end
            rx_wait = no_idle ? 0 : $urandom_range(0, 7);
        end
    end

    // long receiver hold-off partway through the random traffic
    initial begin
        wait (rand_sent >= 200);
        @(posedge aclk);
        stall_rx = 1'b1;
        repeat (300) @(posedge aclk);
        stall_rx = 1'b0;
    end

    initial begin
        sched_item_t   it;
        sched_result_t pred;
        int            pick;
        logic [31:0]   sum;
        logic [31:0]   over;

        for (int i = 0; i < SLOTS; i++) begin
            tk_model[i] = 16'd1;
            run_model[i] = 1'b0;
            ticks_model[i] = '0;
        end

        dir_rows[0]  = row_exp(row(CMD_READ, 0, 0, 0, 0, 0), 0, 0, 0, 1, 0, 0);
        dir_rows[1]  = row_exp(row(CMD_DRAW, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0);
        dir_rows[2]  = row_exp(row(CMD_READ, 63, 0, 0, 0, 0), 0, 0, 0, 1, 0, 0);
        dir_rows[3]  = row_exp(row(CMD_SET, 63, 65535, 1, 0, 0), 0, 0, 65535, 65535, 1, 0);
        dir_rows[4]  = row_exp(row(CMD_CHARGE, 63, 0, 0, 0, 65535),
                               0, 0, 65535, 65535, 1, 65535);
        dir_rows[5]  = row_exp(row(CMD_CHARGE, 63, 0, 0, 0, 0), 0, 0, 65535, 65535, 1, 65535);
        dir_rows[6]  = row_exp(row(CMD_DRAW, 0, 0, 0, 0, 0), 1, 63, 65535, 0, 0, 0);
        dir_rows[7]  = row_exp(row(CMD_DRAW, 0, 0, 0, 65535, 0), 1, 63, 65535, 0, 0, 0);
        dir_rows[8]  = row_exp(row(CMD_DRAW, 0, 0, 0, 65536, 0), 0, 0, 65535, 0, 0, 0);
        dir_rows[9]  = row_exp(row(CMD_DRAW, 63, 65535, 1, 4194303, 65535),
                               0, 0, 65535, 0, 0, 0);
        dir_rows[10] = row_exp(row(CMD_SET, 0, 0, 1, 0, 0), 0, 0, 65535, 0, 1, 0);
        dir_rows[11] = row_exp(row(CMD_DRAW, 0, 0, 0, 0, 0), 1, 0, 65535, 0, 0, 0);
        dir_rows[12] = row_exp(row(CMD_DRAW, 0, 0, 0, 1, 0), 1, 63, 65535, 0, 0, 0);
        dir_rows[13] = row(CMD_SET, 0, 65535, 0, 0, 0);
        dir_rows[14] = row(CMD_READ, 0, 0, 0, 0, 0);
        dir_rows[15] = row(CMD_SET, 21, 16'h5555, 1, 0, 0);
        dir_rows[16] = row(CMD_SET, 42, 16'hAAAA, 1, 0, 0);
        dir_rows[17] = row(CMD_CHARGE, 21, 0, 0, 0, 16'h5555);
        dir_rows[18] = row(CMD_CHARGE, 42, 0, 0, 0, 16'hAAAA);
        dir_rows[19] = row(CMD_DRAW, 0, 0, 0, 22'h2AAAAA, 0);
        dir_rows[20] = row(CMD_DRAW, 0, 0, 0, 22'h015555, 0);
        dir_rows[21] = row(CMD_SET, 63, 0, 0, 0, 0);
        dir_rows[22] = row(CMD_READ, 63, 0, 0, 0, 0);
        dir_rows[23] = row(CMD_DRAW, 0, 0, 0, 1, 0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            pred = slot_table_step(dir_rows[i].item);
            send_item(dir_rows[i].item, dir_rows[i].has_exp ? dir_rows[i].exp : pred);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            it.slot = 6'($urandom_range(0, 63));
            it.tk = 16'($urandom);
            it.run = 1'($urandom);
            it.want = 22'($urandom);
            it.elapsed = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                it.cmd = CMD_SET;
                case ($urandom_range(0, 3))
                    0, 1: it.tk = 16'($urandom_range(0, 255));
                    2: it.tk = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: ;
                endcase
                it.run = ($urandom_range(0, 9) < 7);
            end else if (pick < 65) begin
                it.cmd = CMD_DRAW;
                sum = runnable_sum();
                case ($urandom_range(0, 19))
                    0, 1: begin
                        over = sum + $urandom_range(1, 64);
                        it.want = (over > {10'd0, TOTAL_MAX}) ? TOTAL_MAX : over[21:0];
                    end
                    2, 3, 4: ;
                    default: it.want = 22'($urandom_range(0, sum));
                endcase
            end else if (pick < 85) begin
                it.cmd = CMD_CHARGE;
            end else begin
                it.cmd = CMD_READ;
            end
            send_item(it, slot_table_step(it));
            rand_sent++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sched_results_q.size() > 0) @(posedge aclk);
        repeat (SLOTS + 8) @(posedge aclk);
        if (sched_results_q.size() > 0) begin
            $error("%0d expected results never arrived", sched_results_q.size());
            fails++;
        end
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== lottery_ticket_scheduler.f =====
src/lts_pkg.sv
src/lts_ram.sv
src/lts_accum.sv
src/lottery_ticket_scheduler.sv
verif/tb_lottery_ticket_scheduler.sv
